// ===== src/csw_pkg.sv =====
// csw_pkg: shared types, codes, widths and window coefficients for the
// cosine-sum window block. No dependencies; used by every module in src.
package csw_pkg;

    // register map of the configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_TYPE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP   = 2'd2;

    // fixed field widths
    localparam int FRAME_W = 13;
    localparam int STEP_W  = 24;
    localparam int POS_W   = 12;
    localparam int COS_W   = 16;
    localparam int COEF_W  = 18;
    localparam int ACC_W   = 34;
    localparam int LO_W    = 17;

    localparam logic [FRAME_W-1:0] FRAME_LENGTH_RST = 13'd1024;
    localparam logic [STEP_W-1:0]  PHASE_STEP_RST   = 24'd16400;

    typedef enum logic [1:0] {
        WIN_HANN,
        WIN_HAMMING,
        WIN_BLACKMAN,
        WIN_FLATTOP
    } window_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WRITE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       addr_en;
        logic       rom_en;
        logic       mac_en;
        logic [1:0] mac_sel;
        logic       mul_lo;
        logic       mul_hi;
        logic       out_en;
    } csw_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
    } csw_sts_t;

    // Q2.16 coefficient a_k of the selected window, k = 0..4
    function automatic logic signed [COEF_W-1:0] coef(input window_t win,
                                                     input logic [2:0] k);
        logic signed [COEF_W-1:0] c;
        c = '0;
        unique case (win)
            WIN_HANN: begin
                case (k)
                    3'd0:    c = 18'sd32768;
                    3'd1:    c = -18'sd32768;
                    default: c = '0;
                endcase
            end
            WIN_HAMMING: begin
                case (k)
                    3'd0:    c = 18'sd35389;
                    3'd1:    c = -18'sd30147;
                    default: c = '0;
                endcase
            end
            WIN_BLACKMAN: begin
                case (k)
                    3'd0:    c = 18'sd27525;
                    3'd1:    c = -18'sd32768;
                    3'd2:    c = 18'sd5243;
                    default: c = '0;
                endcase
            end
            WIN_FLATTOP: begin
                case (k)
                    3'd0:    c = 18'sd14128;
                    3'd1:    c = -18'sd27304;
                    3'd2:    c = 18'sd18171;
                    3'd3:    c = -18'sd5477;
                    3'd4:    c = 18'sd455;
                    default: c = '0;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

// ===== src/csw_cos_rom.sv =====
// csw_cos_rom: Q1.15 full-cycle cosine table with registered read.
// Half the cycle is stored and mirrored; depends on csw_pkg.
module csw_cos_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                              aclk,
    input  logic                              rd_en,
    input  logic [$clog2(DEPTH)-1:0]          rd_addr,
    output logic signed [csw_pkg::COS_W-1:0]  rd_data
);

    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int HALF      = DEPTH / 2;
    localparam int HALF_W    = $clog2(HALF + 1);
    localparam int TAB_DEPTH = 2 ** HALF_W;

    // cos(2*pi*j/DEPTH) by an integer Taylor series in Q28, rounded to Q15
    function automatic logic signed [csw_pkg::COS_W-1:0] cos_entry(input int unsigned jf);
        logic [63:0]        th;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        th   = (64'd2 * 64'd843314857 * 64'(jf) + 64'(DEPTH / 2)) / 64'(DEPTH);
        t2   = (th * th) >> 28;
        term = 64'd268435456;
        sum  = 64'sd268435456;
        term = ((term * t2) >> 28) / 64'd2;   sum = sum - $signed(term);
        term = ((term * t2) >> 28) / 64'd12;  sum = sum + $signed(term);
        term = ((term * t2) >> 28) / 64'd30;  sum = sum - $signed(term);
        term = ((term * t2) >> 28) / 64'd56;  sum = sum + $signed(term);
        term = ((term * t2) >> 28) / 64'd90;  sum = sum - $signed(term);
        term = ((term * t2) >> 28) / 64'd132; sum = sum + $signed(term);
        term = ((term * t2) >> 28) / 64'd182; sum = sum - $signed(term);
        term = ((term * t2) >> 28) / 64'd240; sum = sum + $signed(term);
        term = ((term * t2) >> 28) / 64'd306; sum = sum - $signed(term);
        term = ((term * t2) >> 28) / 64'd380; sum = sum + $signed(term);
        term = ((term * t2) >> 28) / 64'd462; sum = sum - $signed(term);
        term = ((term * t2) >> 28) / 64'd552; sum = sum + $signed(term);
        r = $signed(($unsigned(sum) + 64'd536870912 + 64'd4096) >> 13) - 64'sd65536;
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end
        if (r < -64'sd32768) begin
            r = -64'sd32768;
        end
        return csw_pkg::COS_W'(r);
    endfunction

    logic signed [csw_pkg::COS_W-1:0] tab [TAB_DEPTH];
    logic [ADDR_W:0]                  mirror;
    logic [HALF_W-1:0]                idx;
    logic signed [csw_pkg::COS_W-1:0] rd_data_reg;

    // constant table for the first half cycle
    for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_tab
        if (g <= HALF) begin : g_used
            assign tab[g] = cos_entry(g);
        end else begin : g_unused
            assign tab[g] = '0;
        end
    end

    // fold the second half onto the first, cos is even
    always_comb begin
        mirror = (ADDR_W + 1)'(DEPTH) - {1'b0, rd_addr};
        if ({1'b0, rd_addr} <= (ADDR_W + 1)'(HALF)) begin
            idx = HALF_W'(rd_addr);
        end else begin
            idx = mirror[HALF_W-1:0];
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= tab[idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/csw_datapath.sv =====
// csw_datapath: frame position, phase, cosine terms, shared multiplier,
// rounding, saturation and output register. Depends on csw_pkg, csw_cos_rom.
module csw_datapath #(
    parameter int MAX_FRAME       = 4096,
    parameter int SAMPLE_BITS     = 16,
    parameter int COS_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS      = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  csw_pkg::csw_cmd_t                  cmd,
    output csw_pkg::csw_sts_t                  sts,
    input  csw_pkg::window_t                   window_type,
    input  logic [csw_pkg::FRAME_W-1:0]        frame_length,
    input  logic [csw_pkg::STEP_W-1:0]         phase_step,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_windowed_sample,
    output logic                               m_frame_last
);

    localparam int ADDR_W  = $clog2(COS_TABLE_DEPTH);
    localparam int SCALE_W = PHASE_BITS + ADDR_W + 1;
    localparam int A_W     = (SAMPLE_BITS > csw_pkg::COS_W) ? SAMPLE_BITS : csw_pkg::COS_W;
    localparam int PROD_W  = A_W + csw_pkg::COEF_W;
    localparam int FULL_W  = A_W + csw_pkg::ACC_W + 2;
    localparam logic signed [FULL_W-1:0] SAT_MAX = (FULL_W'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [FULL_W-1:0] SAT_MIN = -(FULL_W'(1) <<< (SAMPLE_BITS - 1));
    localparam logic signed [FULL_W-1:0] ROUND_HALF = FULL_W'(1) <<< 30;

    // frame position state
    logic [csw_pkg::POS_W-1:0]   pos_reg,   pos_next;
    logic [PHASE_BITS-1:0]       phase_reg, phase_next;
    logic [csw_pkg::FRAME_W-1:0] len_eff;
    logic [csw_pkg::FRAME_W-1:0] pos_plus;
    logic                        last_now;

    // per-item working registers
    logic signed [SAMPLE_BITS-1:0]     sample_reg;
    logic                              last_reg;
    logic [PHASE_BITS-1:0]             ph_base_reg;
    logic [PHASE_BITS-1:0]             ph_run_reg;
    logic [ADDR_W-1:0]                 addr_reg;
    logic [SCALE_W-1:0]                scaled;
    logic signed [csw_pkg::COS_W-1:0]  cos_data;
    logic signed [csw_pkg::ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0]          lo_reg;
    logic signed [PROD_W-1:0]          hi_reg;

    // shared multiplier
    logic signed [A_W-1:0]              mul_a;
    logic signed [csw_pkg::COEF_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]           mul_out;

    // output stage
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          out_last_reg;
    logic signed [FULL_W-1:0]      full;
    logic signed [FULL_W-1:0]      rnd;
    logic signed [SAMPLE_BITS-1:0] sat_val;

    // effective frame length and last-sample flag
    always_comb begin
        len_eff = frame_length;
        if (frame_length == '0) begin
            len_eff = csw_pkg::FRAME_W'(1);
        end else if (32'(frame_length) > MAX_FRAME) begin
            len_eff = csw_pkg::FRAME_W'(MAX_FRAME);
        end
        pos_plus = {1'b0, pos_reg} + csw_pkg::FRAME_W'(1);
        last_now = (pos_plus >= len_eff);
        if (last_now) begin
            pos_next   = '0;
            phase_next = '0;
        end else begin
            pos_next   = pos_plus[csw_pkg::POS_W-1:0];
            phase_next = phase_reg + PHASE_BITS'(phase_step);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            phase_reg <= '0;
        end else if (cmd.load) begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
        end
    end

    // cosine address: top bits of k times the phase
    assign scaled = SCALE_W'(ph_run_reg) * SCALE_W'(COS_TABLE_DEPTH);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg  <= s_sample_in;
            last_reg    <= last_now;
            ph_base_reg <= phase_reg;
            ph_run_reg  <= phase_reg;
        end else if (cmd.addr_en) begin
            addr_reg   <= scaled[PHASE_BITS +: ADDR_W];
            ph_run_reg <= ph_run_reg + ph_base_reg;
        end
    end

    csw_cos_rom #(
        .DEPTH (COS_TABLE_DEPTH)
    ) u_cos_rom (
        .aclk    (aclk),
        .rd_en   (cmd.rom_en),
        .rd_addr (addr_reg),
        .rd_data (cos_data)
    );

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = A_W'(cos_data);
        mul_b = csw_pkg::coef(window_type, {1'b0, cmd.mac_sel} + 3'd1);
        if (cmd.mul_lo) begin
            mul_a = A_W'(sample_reg);
            mul_b = $signed({1'b0, acc_reg[csw_pkg::LO_W-1:0]});
        end else if (cmd.mul_hi) begin
            mul_a = A_W'(sample_reg);
            mul_b = csw_pkg::COEF_W'($signed(acc_reg[csw_pkg::ACC_W-1:csw_pkg::LO_W]));
        end
    end

    assign mul_out = mul_a * mul_b;

    // weight accumulation and the two partial products of sample times weight
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            acc_reg <= csw_pkg::ACC_W'(csw_pkg::coef(window_type, 3'd0)) <<< 15;
        end else if (cmd.mac_en) begin
            acc_reg <= acc_reg + csw_pkg::ACC_W'(mul_out);
        end
        if (cmd.mul_lo) begin
            lo_reg <= mul_out;
        end
        if (cmd.mul_hi) begin
            hi_reg <= mul_out;
        end
    end

    // recombine, round half up, saturate
    always_comb begin
        full = (FULL_W'(hi_reg) <<< csw_pkg::LO_W) + FULL_W'(lo_reg) + ROUND_HALF;
        rnd  = full >>> 31;
        if (rnd > SAT_MAX) begin
            sat_val = SAMPLE_BITS'(SAT_MAX);
        end else if (rnd < SAT_MIN) begin
            sat_val = SAMPLE_BITS'(SAT_MIN);
        end else begin
            sat_val = SAMPLE_BITS'(rnd);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_en) begin
            out_sample_reg <= sat_val;
            out_last_reg   <= last_reg;
        end
    end

    assign sts.out_free      = !out_valid_reg || m_ready;
    assign m_valid           = out_valid_reg;
    assign m_windowed_sample = out_sample_reg;
    assign m_frame_last      = out_last_reg;

endmodule

// ===== src/csw_ctrl.sv =====
// csw_ctrl: sequencer that steps one request through the datapath.
// Depends on csw_pkg.
module csw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  csw_pkg::csw_sts_t sts,
    output csw_pkg::csw_cmd_t cmd
);

    csw_pkg::state_t state_reg, state_next;
    logic [2:0]      step_reg,  step_next;

    // state and step registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= csw_pkg::ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state and command decode
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            csw_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = csw_pkg::ST_RUN;
                    step_next  = '0;
                end
            end
            csw_pkg::ST_RUN: begin
                step_next = step_reg + 3'd1;
                unique case (step_reg)
                    3'd0: begin
                        cmd.addr_en = 1'b1;
                    end
                    3'd1: begin
                        cmd.addr_en = 1'b1;
                        cmd.rom_en  = 1'b1;
                    end
                    3'd2: begin
                        cmd.addr_en = 1'b1;
                        cmd.rom_en  = 1'b1;
                        cmd.mac_en  = 1'b1;
                        cmd.mac_sel = 2'd0;
                    end
                    3'd3: begin
                        cmd.addr_en = 1'b1;
                        cmd.rom_en  = 1'b1;
                        cmd.mac_en  = 1'b1;
                        cmd.mac_sel = 2'd1;
                    end
                    3'd4: begin
                        cmd.rom_en  = 1'b1;
                        cmd.mac_en  = 1'b1;
                        cmd.mac_sel = 2'd2;
                    end
                    3'd5: begin
                        cmd.mac_en  = 1'b1;
                        cmd.mac_sel = 2'd3;
                    end
                    3'd6: begin
                        cmd.mul_lo = 1'b1;
                    end
                    3'd7: begin
                        cmd.mul_hi = 1'b1;
                        state_next = csw_pkg::ST_WRITE;
                    end
                endcase
            end
            csw_pkg::ST_WRITE: begin
                if (sts.out_free) begin
                    cmd.out_en = 1'b1;
                    state_next = csw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = csw_pkg::ST_IDLE;
            end
        endcase
    end

    // result only written into a free output register
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_en |-> sts.out_free)
        else $error("result written over a pending output");

    // shared multiplier has one user per cycle
    a_mul_single: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.mac_en, cmd.mul_lo, cmd.mul_hi}))
        else $error("multiplier claimed twice");

    // a new request starts the address sequence straight away
    a_load_then_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.addr_en)
        else $error("address step missing after load");

    // no request taken while one is in flight
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mac_en || cmd.mul_lo || cmd.mul_hi || cmd.out_en) |-> !cmd.load)
        else $error("load during a busy sequence");

endmodule

// ===== src/cosine_sum_window_apply.sv =====
// cosine_sum_window_apply: applies a Hann, Hamming, Blackman or flat-top weight
// to each sample. A new request is taken only once the last result is in the output
// register; the shared multiplier (four cosine terms plus two partial products of
// sample times weight) behind the registered cosine ROM serves one request at a time.
// The output register frees the input side while a result waits.
// Synchronous active-low reset clears frame position, phase and handshakes and
// loads the register defaults; no clearing pass. Depends on csw_pkg, csw_ctrl,
// csw_datapath.
module cosine_sum_window_apply #(
    parameter int MAX_FRAME       = 4096,
    parameter int SAMPLE_BITS     = 16,
    parameter int COS_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS      = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [csw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [csw_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_windowed_sample,
    output logic                               m_frame_last
);

    csw_pkg::window_t            window_type_reg;
    logic [csw_pkg::FRAME_W-1:0] frame_length_reg;
    logic [csw_pkg::STEP_W-1:0]  phase_step_reg;
    csw_pkg::csw_cmd_t           cmd;
    csw_pkg::csw_sts_t           sts;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_type_reg  <= csw_pkg::WIN_HANN;
            frame_length_reg <= csw_pkg::FRAME_LENGTH_RST;
            phase_step_reg   <= csw_pkg::PHASE_STEP_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                csw_pkg::CFG_WINDOW_TYPE: begin
                    window_type_reg <= csw_pkg::window_t'(cfg_data[1:0]);
                end
                csw_pkg::CFG_FRAME_LENGTH: begin
                    frame_length_reg <= cfg_data[csw_pkg::FRAME_W-1:0];
                end
                csw_pkg::CFG_PHASE_STEP: begin
                    phase_step_reg <= cfg_data[csw_pkg::STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    csw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    csw_datapath #(
        .MAX_FRAME       (MAX_FRAME),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
        .PHASE_BITS      (PHASE_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .window_type       (window_type_reg),
        .frame_length      (frame_length_reg),
        .phase_step        (phase_step_reg),
        .s_sample_in       (s_sample_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_windowed_sample (m_windowed_sample),
        .m_frame_last      (m_frame_last)
    );

endmodule

// ===== sim/cosine_sum_window_apply_test.sv =====
// cosine_sum_window_apply_test: self-checking bench for the cosine-sum window block, with a
// bit-exact windowing predictor, directed corner cases and randomised traffic with back-pressure.
// Depends on csw_pkg and cosine_sum_window_apply from src.
module cosine_sum_window_apply_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W    = 16;
    localparam int COS_DEPTH   = 1024;
    localparam int LONGEST     = 4096;
    localparam int OVERSIZE_N  = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1_000_000;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic [csw_pkg::CFG_DATA_W-1:0] HALF_TURN = 24'h800000;
    localparam logic [csw_pkg::CFG_DATA_W-1:0] STEP_TOP  = 24'hffffff;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] windowed;
        logic                       last;
    } windowed_result_t;

    // predicts windowed samples and frame flags, checks them in order
    class windowing_scoreboard;
        int                                cos_q15 [COS_DEPTH];
        int                                coef_q16 [4][5];
        csw_pkg::window_t                  window;
        logic [csw_pkg::FRAME_W-1:0]       frame_length;
        logic [csw_pkg::STEP_W-1:0]        phase_step;
        logic [csw_pkg::POS_W-1:0]         position;
        logic [csw_pkg::STEP_W-1:0]        phase;
        windowed_result_t                  windowed_due [$];
        int                                fail_count;

        function new();
            longint unsigned folded, theta, theta_sq, term;
            longint          series, rounded;
            coef_q16 = '{'{32768, -32768, 0, 0, 0},
                         '{35389, -30147, 0, 0, 0},
                         '{27525, -32768, 5243, 0, 0},
                         '{14128, -27304, 18171, -5477, 455}};
            // cosine table: Q28 taylor series on the angle folded into [0, pi]
            for (int j = 0; j < COS_DEPTH; j++) begin
                folded   = (j <= COS_DEPTH / 2) ? j : COS_DEPTH - j;
                theta    = (2 * 64'd843314857 * folded + COS_DEPTH / 2) / COS_DEPTH;
                theta_sq = (theta * theta) >> 28;
                term     = 64'd268435456;
                series   = 268435456;
                for (int n = 1; n <= 12; n++) begin
                    term = ((term * theta_sq) >> 28) / ((2 * n - 1) * (2 * n));
                    if (n % 2 == 1)
                        series -= longint'(term);
                    else
                        series += longint'(term);
                end
                // Q28 to Q15, half up, clamped to the signed range
                rounded = ((series + 2 * 268435456 + 4096) >>> 13) - 65536;
                if (rounded > 32767)
                    rounded = 32767;
                if (rounded < -32768)
                    rounded = -32768;
                cos_q15[j] = int'(rounded);
            end
            window       = csw_pkg::WIN_HANN;
            frame_length = csw_pkg::FRAME_LENGTH_RST;
            phase_step   = csw_pkg::PHASE_STEP_RST;
            position     = '0;
            phase        = '0;
            fail_count   = 0;
        endfunction

        function void write_register(logic [csw_pkg::CFG_INDEX_W-1:0] index,
                                     logic [csw_pkg::CFG_DATA_W-1:0] data);
            case (index)
                csw_pkg::CFG_WINDOW_TYPE:  window       = csw_pkg::window_t'(data[1:0]);
                csw_pkg::CFG_FRAME_LENGTH: frame_length = data[csw_pkg::FRAME_W-1:0];
                csw_pkg::CFG_PHASE_STEP:   phase_step   = data[csw_pkg::STEP_W-1:0];
                default: ;
            endcase
        endfunction

        // accepted request: weight it and move the frame position on
        function void take_sample(logic signed [SAMPLE_W-1:0] pcm);
            longint                     weight, product, scaled;
            logic [csw_pkg::STEP_W-1:0] angle;
            int                         span;
            windowed_result_t           due;
            weight = longint'(coef_q16[int'(window)][0]) * 32768;
            for (int k = 1; k < 5; k++) begin
                angle = csw_pkg::STEP_W'(k * phase);
                weight += longint'(coef_q16[int'(window)][k]) * cos_q15[angle[23:14]];
            end
            product = longint'(pcm) * weight;
            scaled  = (product + (longint'(1) <<< 30)) >>> 31;
            if (scaled > longint'(SAMPLE_MAX))
                scaled = longint'(SAMPLE_MAX);
            if (scaled < longint'(SAMPLE_MIN))
                scaled = longint'(SAMPLE_MIN);
            due.windowed = scaled[SAMPLE_W-1:0];

            // short and long frames clamp; a shrunk frame ends at once
            span = int'(frame_length);
            if (span < 1)
                span = 1;
            if (span > LONGEST)
                span = LONGEST;
            due.last = (int'(position) + 1 >= span);
            if (due.last) begin
                position = '0;
                phase    = '0;
            end else begin
                position = position + 1'b1;
                phase    = phase + phase_step;
            end
            windowed_due.push_back(due);
        endfunction

        function void check_windowed(logic signed [SAMPLE_W-1:0] windowed, logic last);
            windowed_result_t due;
            if (windowed_due.size() == 0) begin
                $display("%0t: result with nothing due: windowed_sample %0d frame_last %0b",
                         $time, windowed, last);
                fail_count++;
                return;
            end
            due = windowed_due.pop_front();
            if (windowed !== due.windowed) begin
                $display("%0t: windowed_sample expected %0d, got %0d",
                         $time, due.windowed, windowed);
                fail_count++;
            end
            if (last !== due.last) begin
                $display("%0t: frame_last expected %0b, got %0b", $time, due.last, last);
                fail_count++;
            end
        endfunction

        function int pending();
            return windowed_due.size();
        endfunction
    endclass

    logic                                aclk        = 1'b0;
    logic                                aresetn     = 1'b0;
    logic                                cfg_valid   = 1'b0;
    logic                                cfg_ready;
    logic [csw_pkg::CFG_INDEX_W-1:0]     cfg_index   = '0;
    logic [csw_pkg::CFG_DATA_W-1:0]      cfg_data    = '0;
    logic                                s_valid     = 1'b0;
    logic                                s_ready;
    logic signed [SAMPLE_W-1:0]          s_sample_in = '0;
    logic                                m_valid;
    logic                                m_ready     = 1'b0;
    logic signed [SAMPLE_W-1:0]          m_windowed_sample;
    logic                                m_frame_last;

    windowing_scoreboard sb;
    int                  tx_idle_pct  = 0;
    int                  rx_stall_pct = 0;
    logic                hold_toggle  = 1'b0;
    logic                hold_seen    = 1'b0;
    int                  hold_left    = 0;
    int unsigned         cycle_count  = 0;

    cosine_sum_window_apply u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sample_in       (s_sample_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_windowed_sample (m_windowed_sample),
        .m_frame_last      (m_frame_last)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // receiver: long hold-off on request, otherwise random stalls
    always @(posedge aclk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_windowed(m_windowed_sample, m_frame_last);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cosine_sum_window_apply regression: fail");
            $finish;
        end
    end

    // drop the request and wait for every due result
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [csw_pkg::CFG_INDEX_W-1:0] index,
                             input logic [csw_pkg::CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_register(index, data);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] pcm);
        s_valid     <= 1'b1;
        s_sample_in <= pcm;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.take_sample(pcm);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // mostly full-range noise, now and then the extremes or tiny values
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] pcm;
        case ($urandom_range(9))
            0:       pcm = SAMPLE_MAX;
            1:       pcm = SAMPLE_MIN;
            2:       pcm = SAMPLE_W'($urandom_range(2) - 1);
            default: pcm = SAMPLE_W'($urandom());
        endcase
        return pcm;
    endfunction

    initial begin
        csw_pkg::window_t            win;
        idle_mode_t                  mode;
        logic [csw_pkg::FRAME_W-1:0] frame;
        logic [csw_pkg::STEP_W-1:0]  step;
        longint                      matched;
        int                          span;
        int                          n_items;

        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults straight after reset
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample(SAMPLE_W'(-1));

        // three-sample frames put the middle sample at the window peak;
        // the first one also lands beyond the new, shorter frame
        write_reg(csw_pkg::CFG_FRAME_LENGTH, 24'd3);
        write_reg(csw_pkg::CFG_PHASE_STEP, HALF_TURN);
        win = win.first();
        do begin
            write_reg(csw_pkg::CFG_WINDOW_TYPE, csw_pkg::CFG_DATA_W'(win));
            send_sample(SAMPLE_MAX);
            send_sample(SAMPLE_MIN);
            send_sample(SAMPLE_MAX);
            win = win.next();
        end while (win != win.first());

        // degenerate frame lengths and the step extremes
        write_reg(csw_pkg::CFG_FRAME_LENGTH, 24'd0);
        write_reg(csw_pkg::CFG_PHASE_STEP, STEP_TOP);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_W'(1));
        write_reg(csw_pkg::CFG_FRAME_LENGTH, 24'd1);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_W'(-1));
        write_reg(csw_pkg::CFG_FRAME_LENGTH, 24'd2);
        write_reg(csw_pkg::CFG_PHASE_STEP, 24'd0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);

        // oversize frame length with the flat top and the top step
        write_reg(csw_pkg::CFG_WINDOW_TYPE, csw_pkg::CFG_DATA_W'(csw_pkg::WIN_FLATTOP));
        write_reg(csw_pkg::CFG_FRAME_LENGTH, 24'd8191);
        write_reg(csw_pkg::CFG_PHASE_STEP, STEP_TOP);
        for (int i = 0; i < OVERSIZE_N; i++)
            send_sample(pick_sample());

        // random phases under each idling pattern
        mode = mode.first();
        do begin
            for (int ph = 0; ph < 3; ph++) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: frame = csw_pkg::FRAME_W'($urandom_range(40, 2));
                    6, 7:             frame = csw_pkg::FRAME_W'($urandom_range(300, 41));
                    8:                frame = csw_pkg::FRAME_W'($urandom_range(1));
                    default:          frame = csw_pkg::FRAME_W'($urandom_range(8191));
                endcase
                span = (int'(frame) > LONGEST) ? LONGEST : int'(frame);
                if (span < 2 || $urandom_range(99) < 15) begin
                    step = csw_pkg::STEP_W'($urandom());
                end else begin
                    matched = ((64'd1 << 24) + (span - 1) / 2) / (span - 1);
                    step    = (matched > STEP_TOP) ? STEP_TOP : matched[23:0];
                end
                write_reg(csw_pkg::CFG_WINDOW_TYPE, csw_pkg::CFG_DATA_W'($urandom_range(3)));
                write_reg(csw_pkg::CFG_FRAME_LENGTH, csw_pkg::CFG_DATA_W'(frame));
                write_reg(csw_pkg::CFG_PHASE_STEP, step);

                case (mode)
                    IDLE_NONE: begin
                        tx_idle_pct  = 0;
                        rx_stall_pct <= 0;
                    end
                    IDLE_SENDER: begin
                        tx_idle_pct  = 62;
                        rx_stall_pct <= 0;
                    end
                    IDLE_RECEIVER: begin
                        tx_idle_pct  = 0;
                        rx_stall_pct <= 62;
                    end
                    default: begin
                        tx_idle_pct  = 26;
                        rx_stall_pct <= 26;
                    end
                endcase
                // long receiver hold-off while requests keep coming
                if (mode == IDLE_NONE && ph == 1)
                    hold_toggle <= ~hold_toggle;

                n_items = $urandom_range(104, 60);
                for (int i = 0; i < n_items; i++) begin
                    // sender pause until the block has emptied
                    if (mode == IDLE_SENDER && ph == 1 && i == n_items / 2)
                        wait_drained();
                    send_sample(pick_sample());
                end
            end
            mode = mode.next();
        end while (mode != mode.first());

        wait_drained();
        repeat (12) @(posedge aclk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("cosine_sum_window_apply regression: pass");
        else
            $display("cosine_sum_window_apply regression: fail");
        $finish;
    end

endmodule
